// ===== rtl/sdmd_pkg.sv =====
// shared types, constants and divide step for the scaled decimal mul/div unit
package sdmd_pkg;

    localparam int NUM_W          = 96;
    localparam int WORD_W         = 64;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = NUM_W / BITS_PER_STAGE;

    localparam logic [WORD_W-1:0] SCALE = 64'd100000;

    localparam logic FUNC_MUL = 1'b0;
    localparam logic FUNC_DIV = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              dz;
        logic [NUM_W-1:0]  num;
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
    } sdmd_div_t;

    // one restoring step: remainder stays below den, which is at most 2^63
    function automatic sdmd_div_t div_step(input sdmd_div_t s);
        sdmd_div_t         o;
        logic [WORD_W-1:0] rs;
        o  = s;
        rs = {s.rem[WORD_W-2:0], s.num[NUM_W-1]};
        o.num = {s.num[NUM_W-2:0], 1'b0};
        if (rs >= s.den) begin
            o.rem = rs - s.den;
            o.quo = {s.quo[WORD_W-2:0], 1'b1};
        end else begin
            o.rem = rs;
            o.quo = {s.quo[WORD_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== rtl/scaled_decimal_mul_div_unit.sv =====
// top level of the scaled decimal fixed-point multiply/divide unit
//
// operands are signed 64-bit values scaled by 100000; s_func selects
// multiply (product / 100000) or divide (100000 * a / b), both rounded half
// up on magnitudes, sign from the xor of the operand signs, wrapped to 64 bits.
// a zero divisor gives result 0 with m_divide_by_zero set.
// the input channel takes one transfer per cycle; the result channel
// returns results in order, one per input transfer.
// pipeline stages: input register, partial products, product sum,
// 48 divider stages at 2 quotient bits each over a 96-bit dividend,
// rounding, and the output register. throughput is one item per cycle when not stalled.
// both operations share the multiplier and the divider: multiply divides
// the product by 100000, divide divides a * 100000 by |b|.
// when the receiver stalls the whole pipeline holds and s_ready drops;
// nothing is lost or repeated. reset (aresetn low, synchronous) empties the
// pipeline and drops m_valid.
module scaled_decimal_mul_div_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [63:0] s_operand_a,
    input  logic [63:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result,
    output logic        m_divide_by_zero
);
    import sdmd_pkg::*;

    logic en;

    logic              v1_reg, neg1_reg, dz1_reg;
    logic [WORD_W-1:0] ma1_reg, mop1_reg, den1_reg;
    logic [WORD_W-1:0] ma_next, mb_next;

    logic              v2_reg, neg2_reg, dz2_reg;
    logic [WORD_W-1:0] ll_reg, hl_reg, lh_reg, hh_reg, den2_reg;

    sdmd_div_t         div_in_reg;
    sdmd_div_t         chain [DIV_STAGES+1];
    logic [NUM_W-1:0]  prod_next;

    logic              vr_reg, negr_reg, dzr_reg;
    logic [WORD_W-1:0] res_reg, res_next;
    sdmd_div_t         last;

    logic              m_valid_reg, m_dz_reg;
    logic [WORD_W-1:0] m_result_reg, m_result_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // magnitudes and operand selection
    assign ma_next = s_operand_a[63] ? (64'd0 - s_operand_a) : s_operand_a;
    assign mb_next = s_operand_b[63] ? (64'd0 - s_operand_b) : s_operand_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= s_operand_a[63] ^ s_operand_b[63];
            dz1_reg  <= (s_func == FUNC_DIV) && (s_operand_b == 64'd0);
            ma1_reg  <= ma_next;
            mop1_reg <= (s_func == FUNC_DIV) ? SCALE : mb_next;
            den1_reg <= (s_func == FUNC_DIV) ? mb_next : SCALE;
        end
    end

    // partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg <= neg1_reg;
            dz2_reg  <= dz1_reg;
            den2_reg <= den1_reg;
            ll_reg   <= ma1_reg[31:0]  * mop1_reg[31:0];
            hl_reg   <= ma1_reg[63:32] * mop1_reg[31:0];
            lh_reg   <= ma1_reg[31:0]  * mop1_reg[63:32];
            hh_reg   <= ma1_reg[63:32] * mop1_reg[63:32];
        end
    end

    // low 96 bits of the product
    assign prod_next = {32'd0, ll_reg}
                     + {hl_reg, 32'd0}
                     + {lh_reg, 32'd0}
                     + {hh_reg[31:0], 64'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            div_in_reg.neg <= neg2_reg;
            div_in_reg.dz  <= dz2_reg;
            div_in_reg.num <= prod_next;
            div_in_reg.den <= den2_reg;
            div_in_reg.rem <= '0;
            div_in_reg.quo <= '0;
        end
        if (!aresetn) begin
            div_in_reg.valid <= 1'b0;
        end else if (en) begin
            div_in_reg.valid <= v2_reg;
        end
    end

    assign chain[0] = div_in_reg;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        sdmd_div_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (chain[k]),
            .d_out   (chain[k+1])
        );
    end

    assign last = chain[DIV_STAGES];

    // round half up
    assign res_next = last.quo
        + {{(WORD_W-1){1'b0}}, ({last.rem, 1'b0} >= {1'b0, last.den})};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
        end else if (en) begin
            vr_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            negr_reg <= last.neg;
            dzr_reg  <= last.dz;
            res_reg  <= res_next;
        end
    end

    // sign and zero-divisor result
    always_comb begin
        if (dzr_reg) begin
            m_result_next = '0;
        end else if (negr_reg) begin
            m_result_next = 64'd0 - res_reg;
        end else begin
            m_result_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_reg <= m_result_next;
            m_dz_reg     <= dzr_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result         = m_result_reg;
    assign m_divide_by_zero = m_dz_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result == 64'd0)
        else $error("zero divisor result not zero");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stall");

    a_round_feeds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        vr_reg && en |=> m_valid)
        else $error("rounded result lost");
`endif

endmodule

// ===== rtl/sdmd_div_stage.sv =====
// one registered stage of the pipelined restoring divider
module sdmd_div_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  sdmd_pkg::sdmd_div_t d_in,
    output sdmd_pkg::sdmd_div_t d_out
);
    import sdmd_pkg::*;

    sdmd_div_t stage_reg;
    sdmd_div_t stage_next;

    always_comb begin
        stage_next = d_in;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            stage_next = div_step(stage_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign d_out = stage_reg;

endmodule
